// File: src/csr_pkg.sv
// Shared types and constants for the compressed-row sparse matrix store.
package csr_pkg;

    // Sizing of the store
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 1024;
    localparam int CAPACITY = 256;

    // Field and register widths
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int VAL_W    = 32;
    localparam int NROW_W   = $clog2(MAX_ROWS + 1);
    localparam int NCOL_W   = $clog2(MAX_COLS + 1);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int RS_DEPTH = MAX_ROWS + 1;
    localparam int RS_AW    = $clog2(RS_DEPTH);

    // Configuration register indexes (byte offset / 4)
    typedef enum logic {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } t_reg;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Request transaction
    typedef struct packed {
        logic                    req_type;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_req;

    // Response transaction
    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        t_status                 status;
    } t_resp;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic rs_pair_rd;
        logic bounds_ld;
        logic scan_en;
        logic res_hit;
        logic res_zero;
        logic res_range;
        logic res_full;
        logic shift_init;
        logic shift_en;
        logic ins_wr;
        logic inc_en;
        logic cnt_inc;
        logic out_ld;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic range_ok;
        logic is_wr;
        logic scan_hit;
        logic scan_miss;
        logic full;
        logic shift_done;
        logic inc_done;
        logic out_free;
    } t_sts;

endpackage

// File: src/csr_ctrl.sv
// Sequencing state machine for the sparse matrix store.
module csr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  csr_pkg::t_sts i_sts,
    output csr_pkg::t_cmd o_cmd
);
    import csr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CHECK   = 8'b0000_0010,
        S_RS_WAIT = 8'b0000_0100,
        S_SCAN    = 8'b0000_1000,
        S_SHIFT   = 8'b0001_0000,
        S_INSERT  = 8'b0010_0000,
        S_RS_INC  = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.range_ok) begin
                    o_cmd.res_range = 1'b1;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.rs_pair_rd = 1'b1;
                    n_state          = S_RS_WAIT;
                end
            end
            S_RS_WAIT: begin
                o_cmd.bounds_ld = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                priority if (i_sts.scan_hit) begin
                    o_cmd.res_hit = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_sts.scan_miss && !i_sts.is_wr) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_FINISH;
                end else if (i_sts.scan_miss && i_sts.full) begin
                    o_cmd.res_full = 1'b1;
                    n_state        = S_FINISH;
                end else if (i_sts.scan_miss) begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end else begin
                    o_cmd.scan_en = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_INSERT;
                end else begin
                    o_cmd.shift_en = 1'b1;
                end
            end
            S_INSERT: begin
                o_cmd.ins_wr = 1'b1;
                n_state      = S_RS_INC;
            end
            S_RS_INC: begin
                if (i_sts.inc_done) begin
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.inc_en = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/csr_dp.sv
// Datapath: entry memories, row-start table, counters and output register.
module csr_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  csr_pkg::t_req                i_in_data,
    input  logic [csr_pkg::NROW_W-1:0]   i_num_rows,
    input  logic [csr_pkg::NCOL_W-1:0]   i_num_cols,
    input  csr_pkg::t_cmd                i_cmd,
    output csr_pkg::t_sts                o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output csr_pkg::t_resp               o_out_data
);
    import csr_pkg::*;

    // Captured request and result
    t_req                r_req;
    t_resp               r_res;
    t_resp               r_out;
    logic                r_out_vld;

    // Entry memories (column index and value per stored entry)
    logic [COL_W-1:0]    r_col_mem [CAPACITY];
    logic [VAL_W-1:0]    r_val_mem [CAPACITY];
    logic [COL_W-1:0]    r_col_rd;
    logic [VAL_W-1:0]    r_val_rd;

    // Row-start table with per-entry valid bits (invalid reads as zero)
    logic [CNT_W-1:0]    r_rs_mem [RS_DEPTH];
    logic [RS_DEPTH-1:0] r_rs_vld;
    logic [CNT_W-1:0]    r_rs_a;
    logic [CNT_W-1:0]    r_rs_b;

    // Sweep state
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [CNT_W-1:0]    r_ins;
    logic [CNT_W-1:0]    r_k;
    logic                r_pend;
    logic [ADDR_W-1:0]   r_pend_k;
    logic [RS_AW-1:0]    r_rk;
    logic                r_rs_pend;
    logic [RS_AW-1:0]    r_rs_pend_a;

    // Memory port controls
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_ra;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    logic [COL_W-1:0]    mem_wcol;
    logic [VAL_W-1:0]    mem_wval;
    logic                rs_re_a;
    logic [RS_AW-1:0]    rs_ra_a;
    logic [RS_AW-1:0]    rs_ra_b;
    logic                rs_we;

    logic                scan_issue;
    logic                scan_hit;
    logic                shift_issue;
    logic                inc_issue;
    logic [RS_AW-1:0]    row_ext;
    logic [CNT_W-1:0]    cap_c;

    assign cap_c       = CNT_W'(CAPACITY);
    assign row_ext     = RS_AW'(r_req.row);
    assign scan_hit    = r_pend && (r_col_rd == r_req.col);
    assign scan_issue  = (r_k < r_hi) && !scan_hit;
    assign shift_issue = (r_k > r_ins);
    assign inc_issue   = (r_rk <= RS_AW'(MAX_ROWS));

    // Status back to the controller
    always_comb begin
        o_sts.range_ok   = (NROW_W'(r_req.row) < i_num_rows)
                        && (NROW_W'(r_req.row) < NROW_W'(MAX_ROWS))
                        && (NCOL_W'(r_req.col) < i_num_cols)
                        && (NCOL_W'(r_req.col) < NCOL_W'(MAX_COLS));
        o_sts.is_wr      = r_req.req_type;
        o_sts.scan_hit   = scan_hit;
        o_sts.scan_miss  = !r_pend && !(r_k < r_hi);
        o_sts.full       = (r_cnt >= cap_c);
        o_sts.shift_done = !r_pend && !shift_issue;
        o_sts.inc_done   = !r_rs_pend && !inc_issue;
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

    // Entry memory port selection
    always_comb begin
        mem_re   = 1'b0;
        mem_ra   = r_k[ADDR_W-1:0];
        mem_we   = 1'b0;
        mem_wa   = r_pend_k;
        mem_wcol = r_col_rd;
        mem_wval = r_val_rd;
        if (i_cmd.scan_en) begin
            mem_re = scan_issue;
        end
        if (i_cmd.res_hit) begin
            // overwrite of an existing entry
            mem_we   = r_req.req_type;
            mem_wval = r_req.value;
        end
        if (i_cmd.shift_en) begin
            // read k-1, write the previous read one slot up
            mem_re = shift_issue;
            mem_ra = ADDR_W'(r_k - CNT_W'(1));
            mem_we = r_pend;
            mem_wa = r_pend_k + ADDR_W'(1);
        end
        if (i_cmd.ins_wr) begin
            mem_we   = 1'b1;
            mem_wa   = r_ins[ADDR_W-1:0];
            mem_wcol = r_req.col;
            mem_wval = r_req.value;
        end
    end

    // Row-start port selection
    always_comb begin
        rs_re_a = i_cmd.rs_pair_rd || (i_cmd.inc_en && inc_issue);
        rs_ra_a = i_cmd.rs_pair_rd ? row_ext : r_rk;
        rs_ra_b = row_ext + RS_AW'(1);
        rs_we   = i_cmd.inc_en && r_rs_pend;
    end

    // Entry memories
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_col_mem[mem_wa] <= mem_wcol;
            r_val_mem[mem_wa] <= mem_wval;
        end
        if (mem_re) begin
            r_col_rd <= r_col_mem[mem_ra];
            r_val_rd <= r_val_mem[mem_ra];
        end
    end

    // Row-start storage and registered reads
    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            r_rs_mem[r_rs_pend_a] <= r_rs_a + CNT_W'(1);
        end
        if (rs_re_a) begin
            r_rs_a <= r_rs_vld[rs_ra_a] ? r_rs_mem[rs_ra_a] : '0;
        end
        if (i_cmd.rs_pair_rd) begin
            r_rs_b <= r_rs_vld[rs_ra_b] ? r_rs_mem[rs_ra_b] : '0;
        end
    end

    // Row-start valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_vld <= '0;
        end else if (rs_we) begin
            r_rs_vld[r_rs_pend_a] <= 1'b1;
        end
    end

    // Entry count and sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_rs_pend <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            priority if (i_cmd.bounds_ld) begin
                r_lo   <= r_rs_a;
                r_hi   <= (r_rs_b > cap_c) ? cap_c : r_rs_b;
                r_k    <= r_rs_a;
                r_pend <= 1'b0;
            end else if (i_cmd.scan_en) begin
                r_pend   <= scan_issue;
                r_pend_k <= r_k[ADDR_W-1:0];
                if (scan_issue) begin
                    r_k <= r_k + CNT_W'(1);
                end
            end else if (i_cmd.shift_init) begin
                r_k    <= r_cnt;
                r_ins  <= (r_lo > r_cnt) ? r_cnt : r_lo;
                r_pend <= 1'b0;
            end else if (i_cmd.shift_en) begin
                r_pend   <= shift_issue;
                r_pend_k <= ADDR_W'(r_k - CNT_W'(1));
                if (shift_issue) begin
                    r_k <= r_k - CNT_W'(1);
                end
            end else if (i_cmd.ins_wr) begin
                r_rk      <= row_ext + RS_AW'(1);
                r_rs_pend <= 1'b0;
            end else if (i_cmd.inc_en) begin
                r_rs_pend   <= inc_issue;
                r_rs_pend_a <= r_rk;
                if (inc_issue) begin
                    r_rk <= r_rk + RS_AW'(1);
                end
            end
        end
    end

    // Request capture and result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_data;
        end
        priority if (i_cmd.res_hit) begin
            r_res.result_value <= r_val_rd;
            r_res.status       <= ST_OK;
        end else if (i_cmd.res_range) begin
            r_res.result_value <= '0;
            r_res.status       <= ST_RANGE;
        end else if (i_cmd.res_full) begin
            r_res.result_value <= '0;
            r_res.status       <= ST_FULL;
        end else if (i_cmd.res_zero) begin
            r_res.result_value <= '0;
            r_res.status       <= ST_OK;
        end
        if (i_cmd.out_ld) begin
            r_out <= r_res;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: src/csr_sparse_matrix_store.sv
// Top level of the compressed-row sparse matrix store.
//
// Holds up to 256 entries of a 64 x 1024 matrix of 32-bit signed values in
// compressed-row form and serves one read or write transaction at a time;
// every request gives exactly one response. An out-of-range request goes
// straight to its response; an in-range request reads its row's start pair
// and scans the row's entries. A write that misses and finds room moves the
// later entries up, writes the new entry and bumps the following row starts.
// The entry memories have one read and one write port and are swept one
// entry per cycle; the row-start table is updated one row per cycle. A new
// request is taken while the previous response still waits in the output
// register; only its own response then waits for that register to empty.
// num_rows (offset 0x0) and num_cols (offset 0x4) are written over the APB
// port; the user must write them only while the block is idle, and the block
// itself does not enforce it. They never alter stored entries.
module csr_sparse_matrix_store (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  csr_pkg::t_req  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output csr_pkg::t_resp o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import csr_pkg::*;

    logic [NROW_W-1:0] r_num_rows;
    logic [NCOL_W-1:0] r_num_cols;
    logic              cfg_wr;
    t_cmd              cmd;
    t_sts              sts;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= NROW_W'(MAX_ROWS);
            r_num_cols <= NCOL_W'(MAX_COLS);
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[2]))
                REG_NUM_ROWS: r_num_rows <= pwdata[NROW_W-1:0];
                REG_NUM_COLS: r_num_cols <= pwdata[NCOL_W-1:0];
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (t_reg'(paddr[2]))
            REG_NUM_ROWS: prdata = 32'(r_num_rows);
            REG_NUM_COLS: prdata = 32'(r_num_cols);
        endcase
    end

    csr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    csr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_num_rows  (r_num_rows),
        .i_num_cols  (r_num_cols),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: src/csr_chk.sv
// Port-level checker for the sparse matrix store, bound to the top level.
module csr_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input csr_pkg::t_resp o_out_data,
    input logic           pready
);
    import csr_pkg::*;

    // A pending response holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("response changed while stalled");

    // Error responses carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_RANGE || o_out_data.status == ST_FULL)
        |-> o_out_data.result_value == '0)
        else $error("error response with nonzero value");

    // Only defined status codes appear
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_RANGE
                         || o_out_data.status == ST_FULL))
        else $error("undefined status code");

    // One request in flight: ready drops after an accepted transaction
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    // Config port never stalls
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind csr_sparse_matrix_store csr_chk u_csr_chk (.*);

// File: dv/csr_sparse_matrix_store_test.sv
// Self-checking random and directed test of the compressed-row sparse matrix store.
`timescale 1ns / 1ps

module csr_sparse_matrix_store_test;
    import csr_pkg::*;

    // Request codes
    localparam logic REQ_READ     = 1'b0;
    localparam logic REQ_WRITE    = 1'b1;

    // Mirror of the store: predicts one response per accepted request
    class csr_shadow_store;
        bit [8:0]  row_start [0:MAX_ROWS];
        bit [9:0]  col_index [0:CAPACITY-1];
        bit [31:0] elem_value [0:CAPACITY-1];
        int        entry_count;
        int        num_rows;
        int        num_cols;
        t_resp     expected_resps[$];
        int        mismatch_count;

        function new();
            foreach (row_start[k]) row_start[k] = '0;
            entry_count    = 0;
            num_rows       = 64;
            num_cols       = 1024;
            mismatch_count = 0;
        endfunction

        function void set_config(input t_reg index, input bit [31:0] data);
            if (index == REG_NUM_ROWS)
                num_rows = int'(data[6:0]);
            else if (index == REG_NUM_COLS)
                num_cols = int'(data[10:0]);
        endfunction

        function int pending();
            return expected_resps.size();
        endfunction

        // Apply one request to the mirrored state and return its response
        function t_resp predict_response(input t_req req);
            t_resp resp;
            int    lo, hi, pos, ins, r, c;
            bit [31:0] old_val;
            r = int'(req.row);
            c = int'(req.col);
            resp.result_value = '0;
            resp.status       = ST_OK;
            if (r >= num_rows || r >= MAX_ROWS || c >= num_cols || c >= MAX_COLS) begin
                resp.status = ST_RANGE;
                return resp;
            end
            // scan the row for the column
            lo  = int'(row_start[r]);
            hi  = int'(row_start[r+1]);
            if (hi > CAPACITY) hi = CAPACITY;
            pos = CAPACITY;
            for (int k = lo; k < hi; k++) begin
                if (pos == CAPACITY && int'(col_index[k]) == c) pos = k;
            end
            if (req.req_type == REQ_READ) begin
                if (pos < CAPACITY) resp.result_value = elem_value[pos];
                return resp;
            end
            // overwrite in place
            if (pos < CAPACITY) begin
                old_val           = elem_value[pos];
                elem_value[pos]   = req.value;
                resp.result_value = old_val;
                return resp;
            end
            if (entry_count >= CAPACITY) begin
                resp.status = ST_FULL;
                return resp;
            end
            // insert at row start, shift later entries, bump later row starts
            ins = int'(row_start[r]);
            if (ins > entry_count) ins = entry_count;
            for (int k = entry_count; k > ins; k--) begin
                col_index[k]  = col_index[k-1];
                elem_value[k] = elem_value[k-1];
            end
            col_index[ins]  = req.col;
            elem_value[ins] = req.value;
            for (int k = r + 1; k <= MAX_ROWS; k++) row_start[k] = row_start[k] + 9'd1;
            entry_count++;
            return resp;
        endfunction

        function void note_request(input t_req req);
            expected_resps.push_back(predict_response(req));
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_response(input t_resp got);
            t_resp want;
            if (expected_resps.size() == 0) begin
                report_mismatch($sformatf("unexpected response value=%0d status=%0d",
                                          got.result_value, got.status));
                return;
            end
            want = expected_resps.pop_front();
            if (got.result_value !== want.result_value)
                report_mismatch($sformatf("result_value got %0d want %0d",
                                          got.result_value, want.result_value));
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, want.status));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_req        i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_resp       o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    csr_shadow_store shadow;
    int resp_count;
    int burst_left;
    int cfg_rows;
    int cfg_cols;
    bit long_hold_done;

    csr_sparse_matrix_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock
    always #5 i_clk = ~i_clk;

    // Monitor: sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                shadow.check_response(o_out_data);
                resp_count++;
            end
            if (i_in_valid && o_in_ready)
                shadow.note_request(i_in_data);
        end
    end

    // Receiver: stall pattern in random modes, plus one long hold-off
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(negedge i_clk);
                if (!long_hold_done && resp_count >= 300) begin
                    long_hold_done = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (1500) @(negedge i_clk);
                end else begin
                    case (mode)
                        0: i_out_ready <= 1'b1;
                        1: i_out_ready <= 1'($urandom_range(0, 1));
                        default: i_out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input t_req req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Send one transaction, with burst and gap pacing
    task automatic send_paced(input t_req req);
        int gap;
        send_req(req);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stop offering and wait until every response is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // APB write: setup then access, register written at the access edge
    task automatic apb_write(input t_reg index, input bit [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow.set_config(index, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_shape(input int rows, input int cols);
        drain();
        apb_write(REG_NUM_ROWS, rows);
        apb_write(REG_NUM_COLS, cols);
        cfg_rows = rows & 32'h7f;
        cfg_cols = cols & 32'h7ff;
    endtask

    function automatic t_req make_req(input logic kind, input int row, input int col,
                                      input bit [31:0] data);
        t_req req;
        req.req_type = kind;
        req.row      = row[ROW_W-1:0];
        req.col      = col[COL_W-1:0];
        req.value    = data;
        return req;
    endfunction

    // Random request: mostly in range, columns biased to a small pool for hits
    function automatic t_req random_req();
        t_req req;
        int eff_rows;
        int eff_cols;
        int pick;
        eff_rows = (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
        eff_cols = (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
        req.req_type = ($urandom_range(0, 99) < 50) ? REQ_WRITE : REQ_READ;
        if (eff_rows > 0 && $urandom_range(0, 99) < 88)
            req.row = ROW_W'($urandom_range(0, eff_rows - 1));
        else
            req.row = ROW_W'($urandom);
        pick = $urandom_range(0, 99);
        if (eff_cols > 0 && pick < 45)
            req.col = COL_W'($urandom_range(0, (eff_cols < 8 ? eff_cols : 8) - 1));
        else if (eff_cols > 0 && pick < 52)
            req.col = COL_W'(eff_cols - 1);
        else if (eff_cols > 0 && pick < 88)
            req.col = COL_W'($urandom_range(0, eff_cols - 1));
        else
            req.col = COL_W'($urandom);
        case ($urandom_range(0, 9))
            0: req.value = 32'h0000_0000;
            1: req.value = 32'h8000_0000;
            2: req.value = 32'h7fff_ffff;
            default: req.value = $urandom;
        endcase
        return req;
    endfunction

    // Phase table: shapes including zero, extremes and values above range
    int ph_rows  [8] = '{64,   1,   17,  0,    127,  64,   33,  64};
    int ph_cols  [8] = '{1024, 1,   100, 1024, 2047, 1024, 513, 16};
    int ph_items [8] = '{250,  180, 220, 60,   240,  220,  220, 210};

    // Main sequence
    initial begin
        shadow         = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        resp_count     = 0;
        burst_left     = 0;
        cfg_rows       = 64;
        cfg_cols       = 1024;
        long_hold_done = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: miss, insert, overwrite, corners, zero values, row start shifts
        send_paced(make_req(REQ_READ,  0,  0,    32'h0));
        send_paced(make_req(REQ_WRITE, 0,  0,    32'h7fff_ffff));
        send_paced(make_req(REQ_READ,  0,  0,    32'h0));
        send_paced(make_req(REQ_WRITE, 0,  0,    32'h8000_0000));
        send_paced(make_req(REQ_WRITE, 63, 1023, 32'hffff_ffff));
        send_paced(make_req(REQ_READ,  63, 1023, 32'hdead_beef));
        send_paced(make_req(REQ_WRITE, 63, 1023, 32'h0));
        send_paced(make_req(REQ_READ,  63, 1023, 32'h0));
        send_paced(make_req(REQ_WRITE, 0,  1023, 32'h1234_5678));
        send_paced(make_req(REQ_READ,  0,  0,    32'h0));
        send_paced(make_req(REQ_WRITE, 31, 512,  32'h5555_5555));
        send_paced(make_req(REQ_READ,  31, 511,  32'h0));
        send_paced(make_req(REQ_WRITE, 5,  5,    32'h0));
        send_paced(make_req(REQ_WRITE, 5,  5,    32'haaaa_aaaa));
        send_paced(make_req(REQ_READ,  5,  5,    32'h0));

        // Directed: out-of-range rows and columns
        set_shape(32, 512);
        send_paced(make_req(REQ_READ,  32, 0,    32'h0));
        send_paced(make_req(REQ_WRITE, 0,  512,  32'h1));
        send_paced(make_req(REQ_WRITE, 63, 1023, 32'h2));
        send_paced(make_req(REQ_READ,  31, 511,  32'h0));
        send_paced(make_req(REQ_READ,  31, 512,  32'h0));
        send_paced(make_req(REQ_WRITE, 31, 0,    32'hcafe_f00d));

        // Directed: zero rows makes everything out of range
        set_shape(0, 1024);
        send_paced(make_req(REQ_READ,  0, 0, 32'h0));
        send_paced(make_req(REQ_WRITE, 0, 0, 32'h3));

        // Random phases
        for (int p = 0; p < 8; p++) begin
            set_shape(ph_rows[p], ph_cols[p]);
            repeat (ph_items[p]) send_paced(random_req());
        end

        drain();
        repeat (400) @(negedge i_clk);
        if (shadow.mismatch_count == 0 && shadow.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
